[rtl/bfsa_pkg.sv]
// Package for the best-fit segment allocator: sizes, status codes, commands.
// No dependencies.
`default_nettype none
package bfsa_pkg;
    localparam int MAX_SEGMENTS   = 32;
    localparam int POOL_ADDR_BITS = 23;
    localparam int IDX_W          = $clog2(MAX_SEGMENTS);
    localparam int CNT_W          = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_W          = POOL_ADDR_BITS + 1;

    typedef logic [POOL_ADDR_BITS-1:0] addr_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
endpackage
`default_nettype wire

[rtl/best_fit_segment_allocator_core.sv]
// Top level of the best-fit segment allocator: segment table and its sequencer.
// Depends on bfsa_pkg.
//
// Usage: raise start with cmd, request_bytes and block_offset while busy is low;
// the request is taken at that edge and busy rises. cmd 0 allocates
// request_bytes bytes from the best fitting free segment (least leftover, lowest
// address on a tie); cmd 1 frees the used segment starting at block_offset and
// merges it with free neighbours.
// The table lives in registers. One request walks it entry by entry: a scan pass
// over all segment_count entries, then one shift pass over the tail when an
// entry is inserted (split) or dropped (merge, at most two drops done as one
// two-place shift). One compare/subtract unit serves the scan, and the shift
// makes one move per cycle.
// The result (status, granted_offset) is shown for one cycle with done high;
// busy falls in that same cycle, so the next start may be taken there.
// The receiver cannot stall; done is never held.
// Reset leaves one free segment covering the whole pool at offset zero.
`default_nettype none
module best_fit_segment_allocator_core
    import bfsa_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      cmd,
    input  wire logic [LEN_W-1:0]          request_bytes,
    input  wire logic [POOL_ADDR_BITS-1:0] block_offset,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [POOL_ADDR_BITS-1:0]      granted_offset
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_INS    = 3'd3;
    localparam logic [2:0] S_DROP   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam len_t POOL_LEN = len_t'(1) << POOL_ADDR_BITS;

    addr_t seg_start_reg [MAX_SEGMENTS];
    len_t  seg_len_reg   [MAX_SEGMENTS];
    logic  [MAX_SEGMENTS-1:0] seg_free_reg;
    cnt_t  count_reg;

    logic [2:0] state_reg;
    logic       cmd_reg;
    len_t       want_reg;
    addr_t      off_reg;
    cnt_t       k_reg;
    logic       found_reg;
    idx_t       best_reg;
    len_t       best_left_reg;
    logic [1:0] status_reg;
    addr_t      granted_reg;
    logic       done_reg;
    // merge plan for free: drop count and position
    logic [1:0] ndrop_reg;
    idx_t       drop_at_reg;

    idx_t  k_idx;
    len_t  cur_len;
    logic  cur_free;
    len_t  left;
    logic  fits;
    logic  hit;
    assign k_idx   = k_reg[IDX_W-1:0];
    assign cur_len = seg_len_reg[k_idx];
    assign cur_free = seg_free_reg[k_idx];
    assign left    = cur_len - want_reg;
    assign fits    = cur_free && (cur_len >= want_reg);
    assign hit     = (seg_start_reg[k_idx] == off_reg) && !cur_free;

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            count_reg    <= cnt_t'(1);
            seg_free_reg <= '0;
            seg_free_reg[0] <= 1'b1;
            found_reg    <= 1'b0;
            status_reg   <= ST_OK;
            granted_reg  <= '0;
            seg_start_reg[0] <= '0;
            seg_len_reg[0]   <= POOL_LEN;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        want_reg  <= request_bytes;
                        off_reg   <= block_offset;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // one entry per cycle through the single compare/subtract
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (fits && (!found_reg || left < best_left_reg))
                        begin
                            found_reg     <= 1'b1;
                            best_reg      <= k_idx;
                            best_left_reg <= left;
                        end
                    end
                    else if (hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= k_idx;
                    end
                    if (k_reg + cnt_t'(1) >= count_reg)
                        state_reg <= S_DECIDE;
                    k_reg <= k_reg + cnt_t'(1);
                end
                S_DECIDE:
                begin
                    granted_reg <= '0;
                    status_reg  <= ST_OK;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (want_reg == '0 || !found_reg)
                        begin
                            status_reg <= ST_NOFIT;
                            state_reg  <= S_DONE;
                        end
                        else if (best_left_reg != '0
                                 && count_reg >= cnt_t'(MAX_SEGMENTS))
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            granted_reg <= seg_start_reg[best_reg];
                            seg_len_reg[best_reg]  <= want_reg;
                            seg_free_reg[best_reg] <= 1'b0;
                            if (best_left_reg != '0)
                            begin
                                k_reg     <= count_reg;
                                state_reg <= S_INS;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        if (!found_reg)
                        begin
                            status_reg <= ST_BADADDR;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin : merge_plan
                            logic rf;
                            logic lf;
                            len_t mid;
                            idx_t keep;
                            rf = (cnt_t'(best_reg) + cnt_t'(1) < count_reg)
                                 && seg_free_reg[idx_t'(best_reg + idx_t'(1))];
                            lf = (best_reg != '0)
                                 && seg_free_reg[idx_t'(best_reg - idx_t'(1))];
                            mid = seg_len_reg[best_reg];
                            if (rf)
                                mid = mid + seg_len_reg[idx_t'(best_reg + idx_t'(1))];
                            keep = best_reg;
                            if (lf)
                            begin
                                keep = idx_t'(best_reg - idx_t'(1));
                                mid  = mid + seg_len_reg[keep];
                            end
                            seg_len_reg[keep]  <= mid;
                            seg_free_reg[keep] <= 1'b1;
                            ndrop_reg   <= 2'(rf) + 2'(lf);
                            drop_at_reg <= idx_t'(keep + idx_t'(1));
                            k_reg       <= cnt_t'(keep) + cnt_t'(1);
                            if (rf || lf)
                                state_reg <= S_DROP;
                            else
                                state_reg <= S_DONE;
                        end
                    end
                end
                S_INS:
                begin
                    // shift the tail up one place, then write the remainder
                    if (k_reg > cnt_t'(best_reg) + cnt_t'(1))
                    begin
                        seg_start_reg[k_idx] <= seg_start_reg[idx_t'(k_idx - idx_t'(1))];
                        seg_len_reg[k_idx]   <= seg_len_reg[idx_t'(k_idx - idx_t'(1))];
                        seg_free_reg[k_idx]  <= seg_free_reg[idx_t'(k_idx - idx_t'(1))];
                        k_reg <= k_reg - cnt_t'(1);
                    end
                    else
                    begin
                        seg_start_reg[k_idx] <= granted_reg + want_reg[POOL_ADDR_BITS-1:0];
                        seg_len_reg[k_idx]   <= best_left_reg;
                        seg_free_reg[k_idx]  <= 1'b1;
                        count_reg <= count_reg + cnt_t'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_DROP:
                begin
                    // shift the tail down by ndrop places
                    if (k_reg + cnt_t'(ndrop_reg) < count_reg)
                    begin
                        seg_start_reg[k_idx] <= seg_start_reg[idx_t'(k_reg + cnt_t'(ndrop_reg))];
                        seg_len_reg[k_idx]   <= seg_len_reg[idx_t'(k_reg + cnt_t'(ndrop_reg))];
                        seg_free_reg[k_idx]  <= seg_free_reg[idx_t'(k_reg + cnt_t'(ndrop_reg))];
                        k_reg <= k_reg + cnt_t'(1);
                    end
                    else
                    begin
                        // vacated entries read as used
                        seg_free_reg[k_idx] <= 1'b0;
                        if (ndrop_reg == 2'd2)
                            seg_free_reg[idx_t'(k_idx + idx_t'(1))] <= 1'b0;
                        count_reg <= count_reg - cnt_t'(ndrop_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // an insert only starts with room left in the table
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS |-> count_reg < cnt_t'(MAX_SEGMENTS))
        else $error("insert into full table");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= cnt_t'(1) && count_reg <= cnt_t'(MAX_SEGMENTS))
        else $error("segment count out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("done outside idle");
    a_ok_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> granted_reg == '0)
        else $error("grant on failed request");
    // the down shift starts right after the kept entry
    a_drop_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DROP && $past(state_reg) == S_DECIDE)
        |-> k_reg == cnt_t'(drop_at_reg))
        else $error("drop shift misplaced");
endmodule
`default_nettype wire
